// ===== rtl/gtfn_pkg.sv =====
package gtfn_pkg;

    localparam int RW_FIELD_BITS = 13;
    localparam int ADDR_LSB = 2;
    localparam logic [0:0] REG_ROW_WIDTH = 1'b0;
    localparam int EDGE_LIMIT_BITS = 30;
    localparam int CROSS_LIMIT_BITS = 31;
    localparam int UNIT_SHIFT = 15;
    localparam int QUOT_BITS = 15;
    localparam int DIV_BITS = 48;
    localparam int NORM_BITS = 16;

    typedef struct packed {
        logic full;
        logic empty;
    } gtfn_qstat_t;

endpackage

// ===== rtl/grid_triangulator_face_normals.sv =====
// edges are scaled down one bit at a time (up to COORD_BITS-30 bits) and cross products
//   likewise (up to 30 bits); a degenerate triangle skips the sqrt and the divider
// throughput: a point is taken only once the last has gone into the cell queue; the two
//   triangles of a cell go in turn through the shared normalize unit (sqrt, divider)
// reset: asynchronous, clears control, row_width to min(1024, MAX_ROW_WIDTH); the line
//   buffer is not cleared
module grid_triangulator_face_normals #(
    parameter int MAX_ROW_WIDTH = 4096,
    parameter int INDEX_BITS    = 24,
    parameter int COORD_BITS    = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // point_x, point_y, point_z
    input  logic [((3 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // cloud_start
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // corner_a, corner_b, corner_c, normal_x, normal_y, normal_z
    output logic [((3 * INDEX_BITS + 48 + 7) / 8) * 8 - 1:0] m_tdata,
    // degenerate
    output logic        m_tuser,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import gtfn_pkg::*;

    localparam int RWB = $clog2(MAX_ROW_WIDTH + 1);
    localparam int TDI = ((3 * COORD_BITS + 7) / 8) * 8;
    localparam int TDW = ((3 * INDEX_BITS + 48 + 7) / 8) * 8;
    localparam int EWID = 12 * COORD_BITS + 4 * INDEX_BITS;
    localparam int RW_RESET = (MAX_ROW_WIDTH < 1024) ? MAX_ROW_WIDTH : 1024;

    logic [RWB-1:0]  row_width_reg;
    logic [RWB-1:0]  row_width_next;
    logic [31:0]     wval;
    logic            wr_en;
    logic            q_push;
    logic            q_pop;
    logic [EWID-1:0] q_in;
    logic [EWID-1:0] q_out;
    gtfn_qstat_t     q_stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[ADDR_LSB] == REG_ROW_WIDTH);
    assign wval   = 32'(pwdata[RW_FIELD_BITS-1:0]);
    assign prdata = (paddr[ADDR_LSB] == REG_ROW_WIDTH) ? 32'(row_width_reg) : '0;

    always_comb
    begin
        if (wval == '0)
        begin
            row_width_next = RWB'(1);
        end
        else if (wval > 32'(MAX_ROW_WIDTH))
        begin
            row_width_next = RWB'(MAX_ROW_WIDTH);
        end
        else
        begin
            row_width_next = RWB'(wval);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= RWB'(RW_RESET);
        end
        else if (wr_en)
        begin
            row_width_reg <= row_width_next;
        end
    end

    gtfn_front #(
        .CB  (COORD_BITS),
        .IB  (INDEX_BITS),
        .MAXW(MAX_ROW_WIDTH),
        .RWB (RWB),
        .TDI (TDI),
        .EWID(EWID)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .row_width(row_width_reg),
        .q_push   (q_push),
        .q_data   (q_in),
        .q_stat   (q_stat)
    );

    gtfn_queue #(
        .WIDTH(EWID),
        .DEPTH(2)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data(q_in),
        .pop      (q_pop),
        .pop_data (q_out),
        .stat     (q_stat)
    );

    gtfn_back #(
        .CB  (COORD_BITS),
        .IB  (INDEX_BITS),
        .EWID(EWID),
        .TDW (TDW)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_out),
        .q_stat  (q_stat),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

// ===== rtl/gtfn_ram.sv =====
module gtfn_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ===== rtl/gtfn_queue.sv =====
module gtfn_queue #(
    parameter int WIDTH = 480,
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    push_data,
    input  logic                pop,
    output logic [WIDTH-1:0]    pop_data,
    output gtfn_pkg::gtfn_qstat_t stat
);

    import gtfn_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CNW-1:0]   count_reg;

    assign stat.full  = (count_reg == CNW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && stat.full && !pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && stat.empty))
        else $error("queue pop while empty");

    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> !stat.empty)
        else $error("pushed entry lost");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNW'(DEPTH))
        else $error("queue count out of range");

endmodule

// ===== rtl/gtfn_front.sv =====
module gtfn_front #(
    parameter int CB   = 32,
    parameter int IB   = 24,
    parameter int MAXW = 4096,
    parameter int RWB  = 13,
    parameter int TDI  = 96,
    parameter int EWID = 480
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDI-1:0]        s_tdata,
    input  logic                  s_tuser,
    input  logic [RWB-1:0]        row_width,
    output logic                  q_push,
    output logic [EWID-1:0]       q_data,
    input  gtfn_pkg::gtfn_qstat_t q_stat
);

    import gtfn_pkg::*;

    localparam int CW = $clog2(MAXW);
    localparam int PTW = 3 * CB;
    localparam int CMPW = (RWB > CW + 1) ? RWB : CW + 1;

    typedef enum logic [0:0] {
        F_IDLE,
        F_PROC
    } fstate_t;

    fstate_t        state_reg;
    logic [PTW-1:0] cur_reg;
    logic [PTW-1:0] left_reg;
    logic [PTW-1:0] ul_reg;
    logic [CW-1:0]  cnt_reg;
    logic           pfr_reg;
    logic [IB-1:0]  vi_reg;

    logic [PTW-1:0] up;
    logic           accept;
    logic           emit;
    logic           done;
    logic [CW-1:0]  raddr;
    logic [IB-1:0]  v2;
    logic [IB-1:0]  v3;
    logic [IB-1:0]  v4;
    logic           row_end;

    assign s_tready = (state_reg == F_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign raddr    = s_tuser ? '0 : cnt_reg;

    gtfn_ram #(
        .WIDTH(PTW),
        .DEPTH(MAXW)
    ) u_line (
        .clk  (clk),
        .we   (done),
        .waddr(cnt_reg),
        .wdata(cur_reg),
        .re   (accept),
        .raddr(raddr),
        .rdata(up)
    );

    assign emit = pfr_reg && (cnt_reg != '0)
        && ($signed(cur_reg[CB-1:0]) > 0) && ($signed(left_reg[CB-1:0]) > 0)
        && ($signed(up[CB-1:0]) > 0) && ($signed(ul_reg[CB-1:0]) > 0);
    assign done    = (state_reg == F_PROC) && (!emit || !q_stat.full);
    assign q_push  = done && emit;
    assign v2      = vi_reg - IB'(1);
    assign v3      = v2 - IB'(row_width);
    assign v4      = vi_reg - IB'(row_width);
    assign q_data  = {v4, v3, v2, vi_reg, up, ul_reg, left_reg, cur_reg};
    assign row_end = (CMPW'(cnt_reg) + CMPW'(1)) >= CMPW'(row_width);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cur_reg   <= '0;
            left_reg  <= '0;
            ul_reg    <= '0;
            cnt_reg   <= '0;
            pfr_reg   <= 1'b0;
            vi_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        cur_reg   <= s_tdata[PTW-1:0];
                        state_reg <= F_PROC;
                        if (s_tuser)
                        begin
                            cnt_reg <= '0;
                            pfr_reg <= 1'b0;
                            vi_reg  <= '0;
                        end
                    end
                end
                F_PROC:
                begin
                    if (done)
                    begin
                        ul_reg    <= up;
                        left_reg  <= cur_reg;
                        vi_reg    <= vi_reg + IB'(1);
                        state_reg <= F_IDLE;
                        if (row_end)
                        begin
                            cnt_reg <= '0;
                            pfr_reg <= 1'b1;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + CW'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/gtfn_back.sv =====
module gtfn_back #(
    parameter int CB   = 32,
    parameter int IB   = 24,
    parameter int EWID = 480,
    parameter int TDW  = 120
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [EWID-1:0]       q_data,
    input  gtfn_pkg::gtfn_qstat_t q_stat,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDW-1:0]        m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);

    import gtfn_pkg::*;

    localparam int PTW = 3 * CB;
    localparam int EW = CB + 1;
    localparam int EBASE = 4 * PTW;

    typedef enum logic [3:0] {
        B_IDLE,
        B_EDGE,
        B_SCALE,
        B_CROSS,
        B_SUB,
        B_SCALE2,
        B_SQ,
        B_SUM,
        B_SQRT,
        B_DIVP,
        B_DIV,
        B_OUT
    } bstate_t;

    bstate_t state_reg;
    logic    tri_reg;

    logic                 esgn_reg [6];
    logic [EW-1:0]        emag_reg [6];
    logic signed [61:0]   prod_reg [6];
    logic                 csgn_reg [3];
    logic [62:0]          cmag_reg [3];
    logic [61:0]          sq_reg   [3];
    logic [63:0]          n_reg;
    logic [63:0]          r_reg;
    logic [63:0]          bit_reg;
    logic [DIV_BITS-1:0]  rem_reg  [3];
    logic [DIV_BITS-1:0]  dsh_reg;
    logic [QUOT_BITS-1:0] q_reg    [3];
    logic [3:0]           cnt_reg;
    logic [IB-1:0]        ia_reg;
    logic [IB-1:0]        ib_reg;
    logic [IB-1:0]        ic_reg;
    logic                 last_reg;
    logic                 deg_reg;

    logic [PTW-1:0]       pa;
    logic [PTW-1:0]       pb;
    logic [PTW-1:0]       pc;
    logic signed [EW-1:0] ediff [6];
    logic signed [30:0]   es [6];
    logic signed [62:0]   cd [3];
    logic                 e_big;
    logic                 c_big;
    logic [63:0]          rb;
    logic                 out_free;
    logic [NORM_BITS-1:0] nrm [3];

    assign pa = q_data[PTW-1:0];
    assign pb = tri_reg ? q_data[3*PTW-1:2*PTW] : q_data[2*PTW-1:PTW];
    assign pc = tri_reg ? q_data[4*PTW-1:3*PTW] : q_data[3*PTW-1:2*PTW];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ediff[i]     = $signed({pb[i*CB+CB-1], pb[i*CB +: CB]})
                         - $signed({pa[i*CB+CB-1], pa[i*CB +: CB]});
            ediff[i + 3] = $signed({pc[i*CB+CB-1], pc[i*CB +: CB]})
                         - $signed({pa[i*CB+CB-1], pa[i*CB +: CB]});
        end
        e_big = 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            es[i] = esgn_reg[i] ? -$signed({1'b0, 30'(emag_reg[i])})
                                :  $signed({1'b0, 30'(emag_reg[i])});
            if (64'(emag_reg[i]) >= (64'(1) << EDGE_LIMIT_BITS))
            begin
                e_big = 1'b1;
            end
        end
        cd[0] = $signed({prod_reg[0][61], prod_reg[0]}) - $signed({prod_reg[1][61], prod_reg[1]});
        cd[1] = $signed({prod_reg[2][61], prod_reg[2]}) - $signed({prod_reg[3][61], prod_reg[3]});
        cd[2] = $signed({prod_reg[4][61], prod_reg[4]}) - $signed({prod_reg[5][61], prod_reg[5]});
        c_big = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (cmag_reg[i] >= (63'(1) << CROSS_LIMIT_BITS))
            begin
                c_big = 1'b1;
            end
            nrm[i] = csgn_reg[i] ? -NORM_BITS'(q_reg[i]) : NORM_BITS'(q_reg[i]);
        end
        rb = r_reg + bit_reg;
    end

    assign out_free = !m_tvalid || m_tready;
    assign q_pop    = (state_reg == B_OUT) && out_free && tri_reg;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_EDGE:
            begin
                for (int i = 0; i < 6; i++)
                begin
                    esgn_reg[i] <= ediff[i][EW-1];
                    emag_reg[i] <= ediff[i][EW-1] ? EW'(-ediff[i]) : EW'(ediff[i]);
                end
                ia_reg   <= q_data[EBASE +: IB];
                ib_reg   <= tri_reg ? q_data[EBASE + 2*IB +: IB] : q_data[EBASE + IB +: IB];
                ic_reg   <= tri_reg ? q_data[EBASE + 3*IB +: IB] : q_data[EBASE + 2*IB +: IB];
                last_reg <= tri_reg;
            end
            B_SCALE:
            begin
                if (e_big)
                begin
                    for (int i = 0; i < 6; i++)
                    begin
                        emag_reg[i] <= emag_reg[i] >> 1;
                    end
                end
            end
            B_CROSS:
            begin
                prod_reg[0] <= es[1] * es[5];
                prod_reg[1] <= es[2] * es[4];
                prod_reg[2] <= es[2] * es[3];
                prod_reg[3] <= es[0] * es[5];
                prod_reg[4] <= es[0] * es[4];
                prod_reg[5] <= es[1] * es[3];
            end
            B_SUB:
            begin
                deg_reg <= (cd[0] == '0) && (cd[1] == '0) && (cd[2] == '0);
                for (int i = 0; i < 3; i++)
                begin
                    csgn_reg[i] <= cd[i][62];
                    cmag_reg[i] <= cd[i][62] ? 63'(-cd[i]) : 63'(cd[i]);
                    q_reg[i]    <= '0;
                end
            end
            B_SCALE2:
            begin
                if (c_big)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        cmag_reg[i] <= cmag_reg[i] >> 1;
                    end
                end
            end
            B_SQ:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sq_reg[i] <= cmag_reg[i][30:0] * cmag_reg[i][30:0];
                end
            end
            B_SUM:
            begin
                n_reg   <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
                r_reg   <= '0;
                bit_reg <= 64'(1) << 62;
            end
            B_SQRT:
            begin
                if (n_reg >= rb)
                begin
                    n_reg <= n_reg - rb;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            B_DIVP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[i] <= (DIV_BITS'(cmag_reg[i][30:0]) << UNIT_SHIFT)
                                + DIV_BITS'(r_reg[31:0]);
                end
                dsh_reg <= DIV_BITS'(r_reg[31:0]) << UNIT_SHIFT;
                cnt_reg <= 4'(QUOT_BITS - 1);
            end
            B_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (rem_reg[i] >= dsh_reg)
                    begin
                        rem_reg[i] <= rem_reg[i] - dsh_reg;
                        q_reg[i]   <= {q_reg[i][QUOT_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        q_reg[i] <= {q_reg[i][QUOT_BITS-2:0], 1'b0};
                    end
                end
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 4'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            tri_reg   <= 1'b0;
            m_tvalid  <= 1'b0;
            m_tdata   <= '0;
            m_tuser   <= 1'b0;
            m_tlast   <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready && (state_reg != B_OUT))
            begin
                m_tvalid <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (!q_stat.empty)
                    begin
                        state_reg <= B_EDGE;
                    end
                end
                B_EDGE:   state_reg <= B_SCALE;
                B_SCALE:
                begin
                    if (!e_big)
                    begin
                        state_reg <= B_CROSS;
                    end
                end
                B_CROSS:  state_reg <= B_SUB;
                B_SUB:
                begin
                    if ((cd[0] == '0) && (cd[1] == '0) && (cd[2] == '0))
                    begin
                        state_reg <= B_OUT;
                    end
                    else
                    begin
                        state_reg <= B_SCALE2;
                    end
                end
                B_SCALE2:
                begin
                    if (!c_big)
                    begin
                        state_reg <= B_SQ;
                    end
                end
                B_SQ:     state_reg <= B_SUM;
                B_SUM:    state_reg <= B_SQRT;
                B_SQRT:
                begin
                    if (bit_reg == 64'(1))
                    begin
                        state_reg <= B_DIVP;
                    end
                end
                B_DIVP:   state_reg <= B_DIV;
                B_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= B_OUT;
                    end
                end
                B_OUT:
                begin
                    if (out_free)
                    begin
                        m_tvalid  <= 1'b1;
                        m_tdata   <= TDW'({nrm[2], nrm[1], nrm[0], ic_reg, ib_reg, ia_reg});
                        m_tuser   <= deg_reg;
                        m_tlast   <= last_reg;
                        tri_reg   <= !tri_reg;
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    a_pop_on_second: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (last_reg && !q_stat.empty))
        else $error("cell retired before its second triangle");

    a_out_load_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (m_tvalid && m_tlast))
        else $error("second triangle not presented");

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[3*IB +: 3*NORM_BITS] == '0))
        else $error("degenerate triangle with nonzero normal");

endmodule

// ===== tb/sv/tb_grid_triangulator_face_normals.sv =====
module tb_grid_triangulator_face_normals;

    import gtfn_pkg::*;

    localparam int MAXW = 4096;
    localparam int IDXW = 24;
    localparam int LIMIT = 3000000;
    localparam int DRAIN = 200;

    typedef enum int {CHECK_MODEL, CHECK_NONE, CHECK_FLAT} check_kind_t;

    typedef struct {
        logic [IDXW-1:0] a;
        logic [IDXW-1:0] b;
        logic [IDXW-1:0] c;
        logic [15:0]     nx;
        logic [15:0]     ny;
        logic [15:0]     nz;
        logic            degen;
        logic            last;
    } tri_t;

    typedef struct {
        logic [31:0]     x;
        logic [31:0]     y;
        logic [31:0]     z;
        logic            start;
        check_kind_t     kind;
        logic [IDXW-1:0] v1;
        logic [IDXW-1:0] v2;
        logic [IDXW-1:0] v3;
        logic [IDXW-1:0] v4;
    } point_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    grid_triangulator_face_normals dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // grid tracker state
    int signed   row_x [MAXW];
    int signed   row_y [MAXW];
    int signed   row_z [MAXW];
    longint      left_pt [3];
    longint      ul_pt [3];
    int          col_cnt;
    bit          past_row0;
    logic [IDXW-1:0] vtx_idx;
    int          width_cfg;

    tri_t        tri_q[$];
    int          errors = 0;
    int          n_recv = 0;
    int          cycles = 0;
    int          hold_left = 0;
    bit          hold_done = 0;

    function automatic longint shr0(longint v, int s);
        if (v < 0)
            return -((-v) >> s);
        return v >> s;
    endfunction

    function automatic bit [63:0] isqrt(bit [63:0] n);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] unit_part(longint c, bit [63:0] m);
        bit [63:0] mag;
        bit [63:0] q;
        mag = (c < 0) ? -c : c;
        q = (mag * 32768 + m) / (2 * m);
        return (c < 0) ? 16'(-q) : 16'(q);
    endfunction

    function automatic tri_t face_normal(longint a[3], longint b[3], longint c[3],
                                         logic [IDXW-1:0] ia, logic [IDXW-1:0] ib,
                                         logic [IDXW-1:0] ic, logic last);
        tri_t t;
        longint e[6];
        longint cr[3];
        bit [63:0] mx;
        bit [63:0] mg;
        int s;
        for (int i = 0; i < 3; i++)
        begin
            e[i] = b[i] - a[i];
            e[i+3] = c[i] - a[i];
        end
        mx = 0;
        for (int i = 0; i < 6; i++)
        begin
            mg = (e[i] < 0) ? -e[i] : e[i];
            if (mg > mx)
                mx = mg;
        end
        s = 0;
        while ((mx >> s) >= (64'd1 << 30))
            s++;
        for (int i = 0; i < 6; i++)
            e[i] = shr0(e[i], s);
        cr[0] = e[1] * e[5] - e[2] * e[4];
        cr[1] = e[2] * e[3] - e[0] * e[5];
        cr[2] = e[0] * e[4] - e[1] * e[3];
        t.a = ia;
        t.b = ib;
        t.c = ic;
        t.last = last;
        if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0)
        begin
            t.nx = 0;
            t.ny = 0;
            t.nz = 0;
            t.degen = 1;
            return t;
        end
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            mg = (cr[i] < 0) ? -cr[i] : cr[i];
            if (mg > mx)
                mx = mg;
        end
        s = 0;
        while ((mx >> s) >= (64'd1 << 31))
            s++;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            cr[i] = shr0(cr[i], s);
            mg = (cr[i] < 0) ? -cr[i] : cr[i];
            mx = mx + mg * mg;
        end
        mx = isqrt(mx);
        t.nx = unit_part(cr[0], mx);
        t.ny = unit_part(cr[1], mx);
        t.nz = unit_part(cr[2], mx);
        t.degen = 0;
        return t;
    endfunction

    // advances the grid tracker; returns the number of triangles in tris
    function automatic int track_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                       logic st, output tri_t tris[2]);
        longint cur[3];
        longint up[3];
        logic [IDXW-1:0] v1, v2, v3, v4;
        int n;
        n = 0;
        cur[0] = longint'($signed(px));
        cur[1] = longint'($signed(py));
        cur[2] = longint'($signed(pz));
        if (st)
        begin
            col_cnt = 0;
            past_row0 = 0;
            vtx_idx = 0;
        end
        up[0] = row_x[col_cnt];
        up[1] = row_y[col_cnt];
        up[2] = row_z[col_cnt];
        if (past_row0 && col_cnt > 0 && cur[0] > 0 && left_pt[0] > 0 && up[0] > 0
            && ul_pt[0] > 0)
        begin
            v1 = vtx_idx;
            v2 = v1 - IDXW'(1);
            v3 = v2 - IDXW'(width_cfg);
            v4 = v1 - IDXW'(width_cfg);
            tris[0] = face_normal(cur, left_pt, ul_pt, v1, v2, v3, 1'b0);
            tris[1] = face_normal(cur, ul_pt, up, v1, v3, v4, 1'b1);
            n = 2;
        end
        ul_pt = up;
        row_x[col_cnt] = int'(cur[0]);
        row_y[col_cnt] = int'(cur[1]);
        row_z[col_cnt] = int'(cur[2]);
        left_pt = cur;
        vtx_idx = vtx_idx + IDXW'(1);
        if (col_cnt + 1 >= width_cfg)
        begin
            col_cnt = 0;
            past_row0 = 1;
        end
        else
            col_cnt++;
        return n;
    endfunction

    task automatic send_point(point_row_t p);
        int r;
        int gap;
        int n;
        tri_t tris[2];
        tri_t t;
        r = $urandom_range(0, 19);
        if (r < 10)
            gap = 0;
        else if (r < 18)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 60);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {p.z, p.y, p.x};
        s_tuser <= p.start;
        do
            @(posedge clk);
        while (!s_tready);
        n = track_point(p.x, p.y, p.z, p.start, tris);
        if (p.kind == CHECK_FLAT)
        begin
            t = '{p.v1, p.v2, p.v3, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0};
            tri_q.insert(tri_q.size(), t);
            t = '{p.v1, p.v3, p.v4, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1};
            tri_q.insert(tri_q.size(), t);
        end
        else if (p.kind == CHECK_MODEL)
        begin
            for (int i = 0; i < n; i++)
                tri_q.insert(tri_q.size(), tris[i]);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (tri_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic set_width(logic [31:0] v);
        int w;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(REG_ROW_WIDTH) << ADDR_LSB;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        w = int'(v[RW_FIELD_BITS-1:0]);
        if (w == 0)
            w = 1;
        if (w > MAXW)
            w = MAXW;
        width_cfg = w;
    endtask

    function automatic point_row_t rand_point(bit first);
        point_row_t p;
        int r;
        r = $urandom_range(0, 99);
        p.start = first || ($urandom_range(0, 299) == 0);
        p.kind = CHECK_MODEL;
        p.v1 = 0;
        p.v2 = 0;
        p.v3 = 0;
        p.v4 = 0;
        if (r < 80)
        begin
            p.x = $urandom_range(1, 32'h0010_0000);
            p.y = 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            p.z = 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
        end
        else if (r < 85)
        begin
            p.x = ($urandom_range(0, 1) == 0) ? 32'd0 : (32'h8000_0000 | $urandom());
            p.y = $urandom();
            p.z = $urandom();
        end
        else if (r < 90)
        begin
            p.x = 32'd5;
            p.y = 32'd7;
            p.z = 32'd9;
        end
        else
        begin
            p.x = $urandom() & 32'h7fff_ffff;
            if (p.x == 0)
                p.x = 1;
            p.y = $urandom();
            p.z = $urandom();
        end
        return p;
    endfunction

    point_row_t directed[] = '{
        '{32'd1, 32'd1, 32'd1, 1'b1, CHECK_NONE, 0, 0, 0, 0},
        '{32'd1, 32'd1, 32'd1, 1'b0, CHECK_NONE, 0, 0, 0, 0},
        '{32'd1, 32'd1, 32'd1, 1'b0, CHECK_NONE, 0, 0, 0, 0},
        '{32'd1, 32'd1, 32'd1, 1'b0, CHECK_FLAT, 3, 2, 0, 1},
        '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0, CHECK_NONE, 0, 0, 0, 0},
        '{32'd1, 32'h7fff_ffff, 32'h8000_0000, 1'b0, CHECK_MODEL, 0, 0, 0, 0},
        '{32'd0, 32'd5, 32'd5, 1'b0, CHECK_NONE, 0, 0, 0, 0},
        '{32'h8000_0000, 32'hffff_ffff, 32'd0, 1'b0, CHECK_NONE, 0, 0, 0, 0},
        '{32'd1, 32'd0, 32'd0, 1'b1, CHECK_NONE, 0, 0, 0, 0},
        '{32'd2, 32'd0, 32'd0, 1'b0, CHECK_NONE, 0, 0, 0, 0},
        '{32'd1, 32'd1, 32'd0, 1'b0, CHECK_NONE, 0, 0, 0, 0},
        '{32'd2, 32'd2, 32'd0, 1'b0, CHECK_MODEL, 0, 0, 0, 0},
        '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, CHECK_NONE, 0, 0, 0, 0},
        '{32'd1, 32'h8000_0000, 32'h8000_0000, 1'b0, CHECK_MODEL, 0, 0, 0, 0},
        '{32'h7fff_ffff, 32'h0000_0001, 32'hffff_0000, 1'b0, CHECK_MODEL, 0, 0, 0, 0},
        '{32'd1, 32'hffff_ffff, 32'h7fff_ffff, 1'b0, CHECK_MODEL, 0, 0, 0, 0},
        '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0, CHECK_MODEL, 0, 0, 0, 0},
        '{32'h0002_0000, 32'h0001_0000, 32'h0007_0000, 1'b0, CHECK_MODEL, 0, 0, 0, 0}
    };

    int phase_width[] = '{1, 0, 3, 5, 16, 5000, 4096, 64, 7, 2};
    int phase_items[] = '{80, 60, 150, 150, 150, 60, 40, 150, 150, 120};

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb_grid_triangulator_face_normals failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        tri_t e;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                n_recv <= n_recv + 1;
                if (tri_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected transaction %h deg %b last %b",
                                 m_tdata, m_tuser, m_tlast);
                end
                else
                begin
                    e = tri_q.pop_front();
                    if (m_tdata[23:0] !== e.a || m_tdata[47:24] !== e.b
                        || m_tdata[71:48] !== e.c || m_tdata[87:72] !== e.nx
                        || m_tdata[103:88] !== e.ny || m_tdata[119:104] !== e.nz
                        || m_tuser !== e.degen || m_tlast !== e.last)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch exp %h %h %h n %h %h %h deg %b last %b got %h %b %b",
                                     e.a, e.b, e.c, e.nx, e.ny, e.nz, e.degen, e.last,
                                     m_tdata, m_tuser, m_tlast);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end
            else if (!hold_done && n_recv >= 30)
            begin
                hold_done <= 1'b1;
                hold_left <= 600;
                m_tready <= 1'b0;
            end
            else if ((cycles / 500) % 4 == 0)
                m_tready <= 1'b1;
            else if ($urandom_range(0, 29) == 0)
                m_tready <= 1'b0;
            else
                m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        point_row_t p;
        col_cnt = 0;
        past_row0 = 0;
        vtx_idx = 0;
        width_cfg = 1024;
        for (int i = 0; i < MAXW; i++)
        begin
            row_x[i] = 0;
            row_y[i] = 0;
            row_z[i] = 0;
        end
        for (int i = 0; i < 3; i++)
        begin
            left_pt[i] = 0;
            ul_pt[i] = 0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        set_width(32'd2);
        foreach (directed[i])
            send_point(directed[i]);
        wait_idle();
        for (int ph = 0; ph < phase_width.size(); ph++)
        begin
            set_width(phase_width[ph]);
            for (int i = 0; i < phase_items[ph]; i++)
            begin
                p = rand_point(i == 0);
                send_point(p);
            end
            wait_idle();
        end
        if (errors == 0 && tri_q.size() == 0)
            $display("tb_grid_triangulator_face_normals passed");
        else
            $display("tb_grid_triangulator_face_normals failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gtfn_pkg.sv
rtl/gtfn_ram.sv
rtl/gtfn_queue.sv
rtl/gtfn_front.sv
rtl/gtfn_back.sv
rtl/grid_triangulator_face_normals.sv
tb/sv/tb_grid_triangulator_face_normals.sv
